// ----- rtl/assert_macros.svh -----
// Assertion helpers for the string to integer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define STR2I_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same, on the block clock and reset.
`define STR2I_ASSERT(lbl, prop, msg) \
  `STR2I_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- rtl/str2i_pkg.sv -----
`timescale 1ns / 1ps

package str2i_pkg;

  // Symbol storage is fixed by the two 64-bit alphabet registers.
  localparam int unsigned NUM_SYM   = 16;
  localparam int unsigned SYM_W     = 8;
  localparam int unsigned DIG_W     = $clog2(NUM_SYM);
  localparam int unsigned BASE_W    = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 64;

  localparam int unsigned MAX_SYMBOLS_DEF = 16;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam logic [BASE_W-1:0] BASE_RESET = 5'd10;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SYM_LO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYM_HI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd2;

  // Characters of interest.
  localparam logic [SYM_W-1:0] CH_NUL   = 8'h00;
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
  localparam logic [SYM_W-1:0] CH_TAB   = 8'h09;
  localparam logic [SYM_W-1:0] CH_LF    = 8'h0A;
  localparam logic [SYM_W-1:0] CH_FF    = 8'h0C;

  typedef struct packed {
    logic [NUM_SYM-1:0][SYM_W-1:0] sym;
    logic [BASE_W-1:0]             base;
    logic [BASE_W-1:0]             in_use;
    logic                          ok;
  } cfg_t;

endpackage

// ----- rtl/str2i_cfg.sv -----
`timescale 1ns / 1ps

module str2i_cfg import str2i_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output cfg_t                 cfg_o
);

  localparam logic [BASE_W-1:0] MAX_B = BASE_W'(MAX_SYMBOLS);

  logic [CFG_W-1:0]  sym_lo_q, sym_hi_q;
  logic [BASE_W-1:0] base_q;
  logic              ok_q, ok_d;
  logic [NUM_SYM-1:0][SYM_W-1:0] sym;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_lo_q <= '0;
      sym_hi_q <= '0;
      base_q   <= BASE_RESET;
      ok_q     <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == REG_SYM_LO) sym_lo_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == REG_SYM_HI) sym_hi_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == REG_BASE)   base_q   <= cfg_data_i[BASE_W-1:0];
      ok_q <= ok_d;
    end
  end

  assign sym = {sym_hi_q, sym_lo_q};

  // Full pairwise check over the symbols in use; registered. It is up to
  // the user that the alphabet only changes while the block is idle.
  always_comb begin
    ok_d = (base_q >= BASE_W'(2)) && (base_q <= MAX_B);
    for (int a = 0; a < NUM_SYM; a++) begin
      if (BASE_W'(a) < base_q) begin
        if (sym[a] == CH_PLUS || sym[a] == CH_MINUS || sym[a] == CH_SPACE ||
            sym[a] == CH_NUL) begin
          ok_d = 1'b0;
        end
        for (int b = a + 1; b < NUM_SYM; b++) begin
          if (BASE_W'(b) < base_q && sym[b] == sym[a]) begin
            ok_d = 1'b0;
          end
        end
      end
    end
  end

  assign cfg_o.sym    = sym;
  assign cfg_o.base   = base_q;
  assign cfg_o.in_use = (base_q > MAX_B) ? MAX_B : base_q;
  assign cfg_o.ok     = ok_q;

endmodule

// ----- rtl/str2i_digit.sv -----
`timescale 1ns / 1ps

module str2i_digit import str2i_pkg::*; (
  input  logic [SYM_W-1:0] ch_i,
  input  cfg_t             cfg_i,
  output logic             hit_o,
  output logic [DIG_W-1:0] idx_o
);

  logic [NUM_SYM-1:0] match;

  always_comb begin
    for (int k = 0; k < NUM_SYM; k++) begin
      match[k] = (BASE_W'(k) < cfg_i.in_use) && (cfg_i.sym[k] == ch_i);
    end
  end

  // Lowest matching symbol wins; NUL is never a digit.
  always_comb begin
    idx_o = '0;
    for (int k = NUM_SYM - 1; k >= 0; k--) begin
      if (match[k]) idx_o = DIG_W'(k);
    end
  end

  assign hit_o = (|match) && (ch_i != CH_NUL);

endmodule

// ----- rtl/string_to_int_any_base.sv -----
`timescale 1ns / 1ps
// A result is valid once its last character has passed the input register, the
// parse step (digit compare, multiply-add) and the result register. Throughput:
// one character per cycle, except while the stall below holds the input.
// A held result stalls the input only when the next character also ends a string.
// Reset clears the parse state, the handshake, and sets the alphabet to zero, base 10.
module string_to_int_any_base import str2i_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  localparam int unsigned OUT_W      = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [SYM_W-1:0]     s_axis_tdata,   // [7:0] ch
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,   // [VALUE_WIDTH-1:0] value, zero pad above
  output logic                 m_axis_tuser    // [0] base_ok
);

  localparam logic [1:0] PH_SPACE = 2'd0;
  localparam logic [1:0] PH_SIGN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  cfg_t cfg;

  logic             in_valid_q;
  logic [SYM_W-1:0] in_ch_q;
  logic             in_last_q;

  logic [1:0]             phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;

  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] out_value_q, out_value_d;
  logic                   out_ok_q;

  logic             hit;
  logic [DIG_W-1:0] dig;
  logic             advance, load_out, in_take;
  logic             is_ws;

  str2i_cfg #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cfg_o (cfg)
  );

  str2i_digit u_digit (
    .ch_i  (in_ch_q),
    .cfg_i (cfg),
    .hit_o (hit),
    .idx_o (dig)
  );

  // A character that ends no string never needs the result slot.
  assign advance       = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready);
  assign load_out      = advance && in_last_q;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign is_ws = (in_ch_q == CH_SPACE) || (in_ch_q == CH_TAB) ||
                 (in_ch_q == CH_LF) || (in_ch_q == CH_FF);

  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    if (phase_d == PH_SPACE && !is_ws) phase_d = PH_SIGN;
    if (phase_d == PH_SIGN) begin
      if (in_ch_q == CH_MINUS) begin
        neg_d = !neg_d;
      end else if (in_ch_q != CH_PLUS) begin
        phase_d = PH_DIGIT;
      end
    end
    if (phase_d == PH_DIGIT) begin
      if (!hit) begin
        phase_d = PH_DONE;
      end else begin
        acc_d = acc_q * VALUE_WIDTH'(cfg.base) + VALUE_WIDTH'(dig);
      end
    end
  end

  always_comb begin
    if (!cfg.ok) begin
      out_value_d = '0;
    end else if (neg_d) begin
      out_value_d = '0 - acc_d;
    end else begin
      out_value_d = acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PH_SPACE;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) begin
        // Drop the parse state once a string is finished.
        if (in_last_q) begin
          phase_q <= PH_SPACE;
          neg_q   <= 1'b0;
          acc_q   <= '0;
        end else begin
          phase_q <= phase_d;
          neg_q   <= neg_d;
          acc_q   <= acc_d;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_ch_q   <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (load_out) begin
      out_value_q <= out_value_d;
      out_ok_q    <= cfg.ok;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_W'(out_value_q);
  assign m_axis_tuser  = out_ok_q;

endmodule

// ----- rtl/str2i_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module str2i_checker import str2i_pkg::*; #(
  parameter int unsigned OUT_W = VALUE_WIDTH_DEF
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             s_axis_tlast,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tuser
);

  // A result waiting for its transaction holds its value.
  `STR2I_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // A rejected alphabet always yields zero.
  `STR2I_ASSERT(a_bad_zero, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0, "nonzero value with invalid alphabet")

  // The input stalls only behind a result that the sink is holding off.
  `STR2I_ASSERT(a_stall_cause, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

  // A stall follows only a last character on the input, a stall, or an input with no valid character.
  `STR2I_ASSERT(a_stall_needs_last, !s_axis_tready |-> $past(s_axis_tlast) || $past(!s_axis_tready) || !$past(s_axis_tvalid), "stall without a pending last character")

endmodule

bind string_to_int_any_base str2i_checker #(
  .OUT_W(OUT_W)
) u_str2i_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
